[rtl/core/tsrp_pkg.sv]
// Shared types for the timestamp replay pacer.
// Used by the front end, the queue, the back end and the top level.
`default_nettype none

package tsrp_pkg;

   // Register indexes on the csr_ write port.
   localparam logic [1:0] CSR_PACING_ENABLE = 2'd0;
   localparam logic [1:0] CSR_SPEED_RECIP   = 2'd1;
   localparam logic [1:0] CSR_JITTER_MAX    = 2'd2;

   // Configuration register contents as seen by the datapath.
   typedef struct packed {
      logic        pacing_enable;
      logic [31:0] speed_recip;
      logic [31:0] jitter_max;
   } tsrp_cfg_type;

   // One classified event. For a paced event value holds the feed delta,
   // otherwise it holds the wall time at which the event is released.
   typedef struct packed {
      logic        paced;
      logic [63:0] value;
      logic [15:0] tag;
   } tsrp_entry_type;

   // Queue status seen by the front and back ends.
   typedef struct packed {
      logic full;
      logic empty;
   } tsrp_qstat_type;

endpackage

`default_nettype wire

[rtl/core/tsrp_if.sv]
// Valid/ready channel interfaces for the pacer's event and result streams.
// Self-contained; no package dependency.
`default_nettype none

interface tsrp_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] feed_time_ns;
   logic [63:0] now_ns;
   logic [15:0] event_ref;

   modport source (output valid, output feed_time_ns, output now_ns, output event_ref,
                   input ready);
   modport sink   (input valid, input feed_time_ns, input now_ns, input event_ref,
                   output ready);
endinterface

interface tsrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] release_ns;
   logic        paced;
   logic [15:0] event_ref_out;

   modport source (output valid, output release_ns, output paced, output event_ref_out,
                   input ready);
   modport sink   (input valid, input release_ns, input paced, input event_ref_out,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/tsrp_front.sv]
// Front end: accepts events, latches the anchors and classifies each event.
// Depends on tsrp_pkg and tsrp_req_if.
`default_nettype none

module tsrp_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   tsrp_req_if.sink                      req_chan,
   input  wire tsrp_pkg::tsrp_cfg_type   cfg,
   input  wire tsrp_pkg::tsrp_qstat_type qstat,
   output tsrp_pkg::tsrp_entry_type      push_entry,
   output logic                          push,
   output logic                          anchored,
   output logic [63:0]                   wall_anchor
);

   logic        anchored_ff, anchored_in;
   logic [63:0] feed_anchor_ff, feed_anchor_in;
   logic [63:0] wall_anchor_ff, wall_anchor_in;
   logic [63:0] feed_ref;
   logic        not_early;
   logic [63:0] delta;
   logic        is_paced;

   assign req_chan.ready = !qstat.full;
   assign push           = req_chan.valid && req_chan.ready;

   // The first event is measured against its own timestamp.
   assign feed_ref  = anchored_ff ? feed_anchor_ff : req_chan.feed_time_ns;
   assign not_early = req_chan.feed_time_ns >= feed_ref;
   assign delta     = req_chan.feed_time_ns - feed_ref;
   assign is_paced  = cfg.pacing_enable && not_early;

   always_comb begin
      push_entry.paced = is_paced;
      push_entry.value = is_paced ? delta : req_chan.now_ns;
      push_entry.tag   = req_chan.event_ref;
   end

   always_comb begin
      anchored_in    = anchored_ff;
      feed_anchor_in = feed_anchor_ff;
      wall_anchor_in = wall_anchor_ff;
      if (push && !anchored_ff) begin
         anchored_in    = 1'b1;
         feed_anchor_in = req_chan.feed_time_ns;
         wall_anchor_in = req_chan.now_ns;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchored_ff <= 1'b0;
      end else begin
         anchored_ff <= anchored_in;
      end
      feed_anchor_ff <= feed_anchor_in;
      wall_anchor_ff <= wall_anchor_in;
   end

   assign anchored    = anchored_ff;
   assign wall_anchor = wall_anchor_ff;

endmodule

`default_nettype wire

[rtl/core/tsrp_queue.sv]
// Two-entry queue of classified events between the front and back ends.
// Depends on tsrp_pkg.
`default_nettype none

module tsrp_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire tsrp_pkg::tsrp_entry_type push_entry,
   input  wire logic                     pop,
   output tsrp_pkg::tsrp_entry_type      pop_entry,
   output tsrp_pkg::tsrp_qstat_type      qstat
);

   tsrp_pkg::tsrp_entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry   = slot_ff[rd_ptr_ff];
   assign qstat.full  = count_ff == 2'd2;
   assign qstat.empty = count_ff == 2'd0;

endmodule

`default_nettype wire

[rtl/core/tsrp_back.sv]
// Back end: scales the feed delta of a paced event, adds the wall anchor and
// the optional jitter, and holds each result for the result channel.
// Depends on tsrp_pkg and tsrp_rsp_if.
`default_nettype none

module tsrp_back #(
   parameter int RECIP_FRAC_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tsrp_pkg::tsrp_cfg_type   cfg,
   input  wire logic [63:0]              wall_anchor,
   input  wire tsrp_pkg::tsrp_qstat_type qstat,
   input  wire tsrp_pkg::tsrp_entry_type pop_entry,
   output logic                          pop,
   tsrp_rsp_if.source                    rsp_chan
);

   localparam logic [63:0] RngSeed  = 64'hDEAD_BEEF_CAFE_1234;
   localparam int          SatShift = 64 + RECIP_FRAC_BITS;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_MLO  = 8'b0000_0010,
      S_MHI  = 8'b0000_0100,
      S_SUM  = 8'b0000_1000,
      S_SCL  = 8'b0001_0000,
      S_DIV  = 8'b0010_0000,
      S_JADD = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [63:0] op_ff, op_in;
   logic        paced_ff, paced_in;
   logic [15:0] tag_ff, tag_in;
   logic [63:0] plo_ff, plo_in;
   logic [63:0] phi_ff, phi_in;
   logic [95:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] rng_ff, rng_in;
   logic [63:0] num_ff, num_in;
   logic [32:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;

   logic [63:0] rng_next;
   logic        scale_sat;
   logic [63:0] scaled;
   logic [64:0] anchor_sum;
   logic [32:0] divisor;
   logic [33:0] rem_shift;
   logic [33:0] rem_diff;
   logic [64:0] jitter_sum;

   function automatic logic [63:0] xorshift64(input logic [63:0] s);
      logic [63:0] x;
      x = s ^ (s << 13);
      x = x ^ (x >> 7);
      x = x ^ (x << 17);
      return x;
   endfunction

   assign rng_next   = xorshift64(rng_ff);
   assign scale_sat  = |(prod_ff >> SatShift);
   assign scaled     = scale_sat ? '1 : prod_ff[RECIP_FRAC_BITS +: 64];
   assign anchor_sum = {1'b0, wall_anchor} + {1'b0, scaled};
   assign divisor    = {1'b0, cfg.jitter_max} + 33'd1;
   // Restoring remainder step: one dividend bit enters per cycle.
   assign rem_shift  = {rem_ff, num_ff[63]};
   assign rem_diff   = rem_shift - {1'b0, divisor};
   assign jitter_sum = {1'b0, acc_ff} + {32'b0, rem_ff};

   assign pop = (state_ff == S_IDLE) && !qstat.empty;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      paced_in = paced_ff;
      tag_in   = tag_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      rng_in   = rng_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (!qstat.empty) begin
               op_in    = pop_entry.value;
               acc_in   = pop_entry.value;
               paced_in = pop_entry.paced;
               tag_in   = pop_entry.tag;
               state_in = pop_entry.paced ? S_MLO : S_OUT;
            end
         end
         S_MLO: begin
            plo_in   = 64'(op_ff[31:0]) * 64'(cfg.speed_recip);
            state_in = S_MHI;
         end
         S_MHI: begin
            phi_in   = 64'(op_ff[63:32]) * 64'(cfg.speed_recip);
            state_in = S_SUM;
         end
         S_SUM: begin
            prod_in  = {32'b0, plo_ff} + {phi_ff, 32'b0};
            state_in = S_SCL;
         end
         S_SCL: begin
            acc_in = anchor_sum[64] ? '1 : anchor_sum[63:0];
            if (cfg.jitter_max != 32'd0) begin
               rng_in   = rng_next;
               num_in   = rng_next;
               rem_in   = '0;
               cnt_in   = 6'd63;
               state_in = S_DIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            rem_in   = rem_diff[33] ? rem_shift[32:0] : rem_diff[32:0];
            num_in   = {num_ff[62:0], 1'b0};
            cnt_in   = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               state_in = S_JADD;
            end
         end
         S_JADD: begin
            acc_in   = jitter_sum[64] ? '1 : jitter_sum[63:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rng_ff   <= RngSeed;
      end else begin
         state_ff <= state_in;
         rng_ff   <= rng_in;
      end
      op_ff    <= op_in;
      paced_ff <= paced_in;
      tag_ff   <= tag_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   assign rsp_chan.valid         = state_ff == S_OUT;
   assign rsp_chan.release_ns    = acc_ff;
   assign rsp_chan.paced         = paced_ff;
   assign rsp_chan.event_ref_out = tag_ff;

endmodule

`default_nettype wire

[rtl/core/timestamp_replay_pacer_unit.sv]
// Timestamp replay pacer. Each transfer on req_chan carries a recorded feed
// timestamp, the current wall time and a tag; each transfer on rsp_chan gives
// the wall time at which to release that event. The first event after reset
// sets the feed and wall anchors. A paced event is released at
// wall anchor + (feed delta * speed_recip >> RECIP_FRAC_BITS), plus an
// xorshift64 jitter reduced modulo (jitter_max + 1) when jitter is enabled;
// every sum saturates at all ones. The back end takes one event at a time;
// a paced one passes S_MLO, S_MHI, S_SUM and S_SCL, with jitter also S_DIV,
// a bit-serial remainder using one of the 64 random bits per cycle, and
// S_JADD. A two-entry queue lets the front end keep accepting events while
// a result waits on rsp_chan. The user must write configuration through
// the csr_ port only while no event is in flight; the block does not check.
`default_nettype none

module timestamp_replay_pacer_unit #(
   parameter int RECIP_FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tsrp_req_if.sink         req_chan,
   tsrp_rsp_if.source       rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic        pacing_enable_ff, pacing_enable_in;
   logic [31:0] speed_recip_ff, speed_recip_in;
   logic [31:0] jitter_max_ff, jitter_max_in;

   tsrp_pkg::tsrp_cfg_type   cfg;
   tsrp_pkg::tsrp_qstat_type qstat;
   tsrp_pkg::tsrp_entry_type push_entry;
   tsrp_pkg::tsrp_entry_type pop_entry;
   logic        push;
   logic        pop;
   logic        anchored;
   logic [63:0] wall_anchor;

   always_comb begin
      pacing_enable_in = pacing_enable_ff;
      speed_recip_in   = speed_recip_ff;
      jitter_max_in    = jitter_max_ff;
      if (csr_wr_en) begin
         case (csr_index)
            tsrp_pkg::CSR_PACING_ENABLE: pacing_enable_in = csr_wdata[0];
            tsrp_pkg::CSR_SPEED_RECIP:   speed_recip_in   = csr_wdata;
            tsrp_pkg::CSR_JITTER_MAX:    jitter_max_in    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pacing_enable_ff <= 1'b0;
         speed_recip_ff   <= 32'd65536;
         jitter_max_ff    <= 32'd0;
      end else begin
         pacing_enable_ff <= pacing_enable_in;
         speed_recip_ff   <= speed_recip_in;
         jitter_max_ff    <= jitter_max_in;
      end
   end

   always_comb begin
      cfg.pacing_enable = pacing_enable_ff;
      cfg.speed_recip   = speed_recip_ff;
      cfg.jitter_max    = jitter_max_ff;
   end

   tsrp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .cfg         (cfg),
      .qstat       (qstat),
      .push_entry  (push_entry),
      .push        (push),
      .anchored    (anchored),
      .wall_anchor (wall_anchor)
   );

   tsrp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .qstat      (qstat)
   );

   tsrp_back #(
      .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .wall_anchor (wall_anchor),
      .qstat       (qstat),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

   // A full queue must hold off new events.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !req_chan.ready)
      else $error("event accepted while the queue is full");

   // The back end never takes an entry from an empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("queue popped while empty");

   // Once set, the anchors stay until reset.
   a_anchor_sticky: assert property (@(posedge clock) disable iff (reset)
      anchored |=> anchored)
      else $error("anchor dropped without reset");

   // A transfer into an empty queue always leaves the queue nonempty.
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push && qstat.empty && !pop |=> !qstat.empty)
      else $error("accepted event lost by the queue");

endmodule

`default_nettype wire

[sim/timestamp_replay_pacer_unit_test.sv]
// Self-checking testbench for timestamp_replay_pacer_unit: anchoring, pacing, scaling,
// saturation and jitter, with random idling on both channels and a long result hold-off.
// Depends on tsrp_pkg, the tsrp_req_if/tsrp_rsp_if interfaces and the pacer RTL.
`default_nettype none

module timestamp_replay_pacer_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          FRAC_BITS       = 16;
   localparam logic [63:0] RNG_SEED        = 64'hDEADBEEFCAFE1234;
   localparam logic [63:0] ALL_ONES        = '1;
   localparam int          CYCLE_LIMIT     = 2_000_000;
   localparam int          DRAIN_CYCLES    = 100;
   localparam int          LONG_HOLD       = 400;
   localparam int          RANDOM_PHASES   = 8;
   localparam int          ITEMS_PER_PHASE = 200;

   typedef struct {
      logic [63:0] release_ns;
      logic        paced;
      logic [15:0] event_ref;
   } pacer_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   tsrp_req_if req_if();
   tsrp_rsp_if rsp_if();

   timestamp_replay_pacer_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the block's configuration and state.
   tsrp_pkg::tsrp_cfg_type pacer_cfg;
   logic         is_anchored;
   logic [63:0]  anchor_feed;
   logic [63:0]  anchor_wall;
   logic [63:0]  jitter_rng;

   pacer_result_type pending_releases[$];
   pacer_result_type checked_result;

   int error_count   = 0;
   int cycle_count   = 0;
   int items_sent    = 0;
   int n_paced       = 0;
   int n_unpaced     = 0;
   int n_early       = 0;
   int n_jittered    = 0;
   int n_saturated   = 0;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int stall_left    = 0;
   int hold_req_count = 0;
   int hold_ack_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding.",
                  cycle_count, pending_releases.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic [63:0] add_saturating(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[64] ? ALL_ONES : sum[63:0];
   endfunction

   function automatic logic [63:0] scale_feed_delta(input logic [63:0] delta,
                                                    input logic [31:0] recip);
      logic [95:0] product;
      product = ({32'h0, delta} * {64'h0, recip}) >> FRAC_BITS;
      return (product[95:64] != 0) ? ALL_ONES : product[63:0];
   endfunction

   function automatic logic [63:0] xorshift_next(input logic [63:0] x);
      x = x ^ (x << 13);
      x = x ^ (x >> 7);
      x = x ^ (x << 17);
      return x;
   endfunction

   function automatic pacer_result_type pace_event(input logic [63:0] feed,
                                                   input logic [63:0] now,
                                                   input logic [15:0] tag);
      pacer_result_type res;
      logic [63:0]   offset;
      res.release_ns = now;
      res.paced      = 1'b0;
      res.event_ref  = tag;
      if (!is_anchored) begin
         is_anchored = 1'b1;
         anchor_feed = feed;
         anchor_wall = now;
      end
      if (pacer_cfg.pacing_enable && feed >= anchor_feed) begin
         offset = scale_feed_delta(feed - anchor_feed, pacer_cfg.speed_recip);
         res.release_ns = add_saturating(anchor_wall, offset);
         if (pacer_cfg.jitter_max != 0) begin
            jitter_rng = xorshift_next(jitter_rng);
            res.release_ns = add_saturating(res.release_ns,
                                            jitter_rng % ({32'h0, pacer_cfg.jitter_max} + 64'd1));
            n_jittered++;
         end
         res.paced = 1'b1;
         n_paced++;
         if (res.release_ns == ALL_ONES) begin
            n_saturated++;
         end
      end else begin
         n_unpaced++;
         if (feed < anchor_feed) begin
            n_early++;
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string name, input logic [63:0] expected,
                                       input logic [63:0] actual);
      if (expected !== actual) begin
         $error("%s mismatch: expected %h, got %h", name, expected, actual);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_releases.size() == 0) begin
            $error("Result transfer with no event outstanding: event_ref_out %h",
                   rsp_if.event_ref_out);
            error_count++;
         end else begin
            checked_result = pending_releases.pop_front();
            check_field("release_ns", checked_result.release_ns, rsp_if.release_ns);
            check_field("paced", 64'(checked_result.paced), 64'(rsp_if.paced));
            check_field("event_ref_out", 64'(checked_result.event_ref),
                        64'(rsp_if.event_ref_out));
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   function automatic int gap_length();
      if ($urandom_range(9, 0) == 0) begin
         return $urandom_range(120, 20);
      end
      return $urandom_range(3, 1);
   endfunction

   function automatic int pick_gap(input int pct);
      if ($urandom_range(99, 0) >= pct) begin
         return 0;
      end
      return gap_length();
   endfunction

   // A change of hold_req_count starts one long hold-off of the result channel.
   always @(posedge clock) begin
      if (hold_ack_count != hold_req_count) begin
         hold_ack_count <= hold_req_count;
         stall_left <= LONG_HOLD;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(99, 0) < rsp_stall_pct) begin
         stall_left <= gap_length() - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- sender and registers

   task automatic send_event(input logic [63:0] feed, input logic [63:0] now,
                             input logic [15:0] tag);
      int gap;
      req_if.valid        <= 1'b1;
      req_if.feed_time_ns <= feed;
      req_if.now_ns       <= now;
      req_if.event_ref    <= tag;
      do @(posedge clock); while (!req_if.ready);
      pending_releases.push_back(pace_event(feed, now, tag));
      items_sent++;
      gap = pick_gap(req_idle_pct);
      // With no gap, valid stays high so the next call can present its event at once.
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_until_idle();
      req_if.valid <= 1'b0;
      while (pending_releases.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_pacer(input logic enable, input logic [31:0] recip,
                                input logic [31:0] jitter_max);
      wait_until_idle();
      csr_wr_en <= 1'b1;
      csr_index <= tsrp_pkg::CSR_PACING_ENABLE;
      csr_wdata <= {31'h0, enable};
      @(posedge clock);
      csr_index <= tsrp_pkg::CSR_SPEED_RECIP;
      csr_wdata <= recip;
      @(posedge clock);
      csr_index <= tsrp_pkg::CSR_JITTER_MAX;
      csr_wdata <= jitter_max;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pacer_cfg.pacing_enable = enable;
      pacer_cfg.speed_recip   = recip;
      pacer_cfg.jitter_max    = jitter_max;
   endtask

   // Feed times clustered around the anchor, with some early, some near the top
   // of the range and some fully random.
   function automatic logic [63:0] rand_feed();
      logic [63:0] delta;
      int          width;
      width = $urandom_range(63, 1);
      delta = {$urandom, $urandom} >> (64 - width);
      case ($urandom_range(9, 0))
         0: begin
            return {$urandom, $urandom};
         end
         1: begin
            return {$urandom, $urandom} % anchor_feed;
         end
         2: begin
            return ALL_ONES - {32'h0, $urandom};
         end
         3: begin
            return anchor_feed + 64'($urandom_range(3, 0));
         end
         default: begin
            return anchor_feed + delta;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // Reset leaves pacing off; the first event sets both anchors anyway.
   task automatic test_anchor_and_unpaced();
      send_event({16'h0, 16'($urandom_range(65535, 1)), 32'($urandom)},
                 {8'h0, 24'($urandom), 32'($urandom)}, 16'h0000);
      send_event(64'h0, ALL_ONES, 16'hFFFF);
      send_event(ALL_ONES, 64'h0, 16'h5A5A);
      send_event(anchor_feed + 64'd1000, {$urandom, $urandom}, 16'hA5A5);
   endtask

   task automatic test_real_time_pacing();
      program_pacer(1'b1, 32'd65536, 32'd0);
      send_event(anchor_feed, {$urandom, $urandom}, 16'h0001);
      send_event(anchor_feed + 64'd1, {$urandom, $urandom}, 16'h0002);
      send_event(anchor_feed + 64'd1_000_000, {$urandom, $urandom}, 16'h0003);
      send_event(anchor_feed - 64'd1, {$urandom, $urandom}, 16'h0004);
      send_event(ALL_ONES, {$urandom, $urandom}, 16'h0005);
      send_event(64'h0, {$urandom, $urandom}, 16'h0006);
   endtask

   task automatic test_speed_scaling();
      program_pacer(1'b1, 32'hFFFF_FFFF, 32'd0);
      send_event(anchor_feed + (64'd1 << 48), {$urandom, $urandom}, 16'h0010);
      send_event(anchor_feed + 64'd3, {$urandom, $urandom}, 16'h0011);
      program_pacer(1'b1, 32'd1, 32'd0);
      send_event(anchor_feed + 64'd65535, {$urandom, $urandom}, 16'h0012);
      send_event(anchor_feed + (64'd1 << 60), {$urandom, $urandom}, 16'h0013);
      // A zero reciprocal collapses every paced event onto the wall anchor.
      program_pacer(1'b1, 32'd0, 32'd0);
      send_event(anchor_feed + 64'd12345, {$urandom, $urandom}, 16'h0014);
   endtask

   task automatic test_jitter();
      program_pacer(1'b1, 32'd65536, 32'd1);
      send_event(anchor_feed + 64'd100, {$urandom, $urandom}, 16'h0020);
      send_event(anchor_feed + 64'd100, {$urandom, $urandom}, 16'h0021);
      program_pacer(1'b1, 32'd65536, 32'hFFFF_FFFF);
      send_event(anchor_feed + 64'd10, {$urandom, $urandom}, 16'h0022);
      // Lands five below the top, so any added jitter above five saturates the sum.
      send_event(anchor_feed + (ALL_ONES - anchor_wall - 64'd5), {$urandom, $urandom},
                 16'h0023);
      // Unpaced events must not advance the generator.
      program_pacer(1'b0, 32'd65536, 32'hFFFF_FFFF);
      send_event(anchor_feed + 64'd50, {$urandom, $urandom}, 16'h0024);
      program_pacer(1'b1, 32'd65536, 32'd7);
      send_event(anchor_feed + 64'd50, {$urandom, $urandom}, 16'h0025);
   endtask

   // The result channel is held off while events keep coming back to back.
   task automatic test_result_backpressure();
      program_pacer(1'b1, 32'd65536, 32'd100);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_req_count <= hold_req_count + 1;
      repeat (30) begin
         send_event(rand_feed(), {$urandom, $urandom}, 16'($urandom));
      end
   endtask

   task automatic test_random_traffic();
      logic        enable;
      logic [31:0] recip;
      logic [31:0] jitter_max;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         enable = ($urandom_range(4, 0) != 0);
         case ($urandom_range(4, 0))
            0: recip = 32'd65536;
            1: recip = $urandom_range(65536, 1);
            2: recip = $urandom;
            3: recip = 32'hFFFF_FFFF;
            default: recip = $urandom_range(32'h0010_0000, 32'h0001_0000);
         endcase
         case ($urandom_range(3, 0))
            0: jitter_max = 32'd0;
            1: jitter_max = $urandom_range(1000, 1);
            2: jitter_max = $urandom;
            default: jitter_max = 32'hFFFF_FFFF;
         endcase
         if (phase == 0) begin
            enable = 1'b1;
            recip = 32'hFFFF_FFFF;
            jitter_max = 32'hFFFF_FFFF;
         end else if (phase == 1) begin
            enable = 1'b1;
            recip = 32'd1;
            jitter_max = 32'd0;
         end
         program_pacer(enable, recip, jitter_max);
         // The first phase runs without any idling on either side.
         req_idle_pct  = (phase == 0) ? 0 : $urandom_range(60, 0);
         rsp_stall_pct = (phase == 0) ? 0 : $urandom_range(60, 0);
         repeat (ITEMS_PER_PHASE) begin
            send_event(rand_feed(), {$urandom, $urandom}, 16'($urandom));
         end
      end
   endtask

   initial begin
      pacer_cfg.pacing_enable = 1'b0;
      pacer_cfg.speed_recip   = 32'd65536;
      pacer_cfg.jitter_max    = 32'd0;
      is_anchored = 1'b0;
      anchor_feed = 64'h0;
      anchor_wall = 64'h0;
      jitter_rng  = RNG_SEED;

      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_index           <= tsrp_pkg::CSR_PACING_ENABLE;
      csr_wdata           <= 32'h0;
      req_if.valid        <= 1'b0;
      req_if.feed_time_ns <= 64'h0;
      req_if.now_ns       <= 64'h0;
      req_if.event_ref    <= 16'h0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_anchor_and_unpaced();
      test_real_time_pacing();
      test_speed_scaling();
      test_jitter();
      test_result_backpressure();
      test_random_traffic();

      wait_until_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_releases.size() != 0) begin
         $error("%0d expected results never arrived", pending_releases.size());
         error_count++;
      end

      $display("Sent %0d events: %0d paced (%0d with jitter, %0d saturated at the top),",
               items_sent, n_paced, n_jittered, n_saturated);
      $display("%0d released at once (%0d before the feed anchor); %0d mismatches.",
               n_unpaced, n_early, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
